// ===== src/text_console_writer_core_defines.svh =====
// ----------------------------------------------------------------------------
// text_console_writer_core_defines
// Assertion macros used by the console writer checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// concurrent assertion, disabled while reset is high
`define TCW_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds during reset
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] COLOR_RESET  = 8'h07;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_PUT,
      KIND_NEWLINE,
      KIND_CLEAR,
      KIND_READ,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
      logic [4:0] row;
      logic [6:0] col;
   } cmd_type;

   // first field in the highest bits
   typedef struct packed {
      logic       scrolled;
      logic [7:0] read_color;
      logic [7:0] read_char;
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FILL
   } state_type;

endpackage

// ===== src/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console engine with a character/attribute screen store and a cursor.
// ----------------------------------------------------------------------------
// Requests arrive on req_*: tuser is the op (put, clear, read), tdata holds
// the character and the cell address of a read. Every request yields one
// response on rsp_* with the cursor after the request, the read cell and a
// scroll flag. csr_wr_en/csr_wr_data set the attribute byte for writes and
// fills; write it only while no request is outstanding.
// A two-entry queue decouples request intake from the engine. Puts and
// newlines that do not scroll and unused ops are answered from the idle
// state, reads through the registered store port and the read state. A
// scroll copies the store one cell per cycle and refills the bottom row; a
// clear fills ROWS*COLUMNS cells, one per cycle.
// After reset the engine fills the store with spaces in color 0x07, with
// req_tready low.
// A stalled response holds in the output register; the engine starts no new
// command until it leaves, and the queue takes at most two more requests
// before req_tready drops.
// ----------------------------------------------------------------------------
module text_console_writer_core
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code, cell_row, cell_col, zero pad
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_row, cursor_col, read_char,
                                    // read_color, scrolled, zero pad
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0] text_color_ff;
   logic       q_push, q_ready, q_valid, q_pop, init_busy;
   cmd_type    push_cmd, head_cmd;
   rsp_type    rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= COLOR_RESET;
      end else if (csr_wr_en) begin
         text_color_ff <= csr_wr_data;
      end
   end

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .init_busy  (init_busy),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .push_ready (q_ready),
      .pop_valid  (q_valid),
      .pop_cmd    (head_cmd),
      .pop        (q_pop)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .text_color (text_color_ff),
      .q_valid    (q_valid),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data),
      .init_busy  (init_busy)
   );

   assign rsp_tdata = {3'b0, rsp_data};

endmodule

// ===== src/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Accepts request transactions and classifies them into engine commands.
// ----------------------------------------------------------------------------
module tcw_front
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code, cell_row, cell_col, zero pad
   input  logic [1:0]  req_tuser,   // op
   input  logic        q_ready,
   input  logic        init_busy,
   output logic        q_push,
   output cmd_type     q_cmd
);

   logic [7:0] char_code;
   logic [4:0] cell_row;
   logic [6:0] cell_col;
   logic       in_range;

   assign char_code = req_tdata[7:0];
   assign cell_row  = req_tdata[12:8];
   assign cell_col  = req_tdata[19:13];

   // no transactions while the store is being cleared after reset
   assign req_tready = q_ready && !init_busy;
   assign q_push     = req_tvalid && req_tready;

   assign in_range = (32'(cell_row) < ROWS) && (32'(cell_col) < COLUMNS);

   always_comb begin
      q_cmd.ch  = char_code;
      q_cmd.row = cell_row;
      q_cmd.col = cell_col;
      unique case (op_type'(req_tuser))
         OP_PUT:   q_cmd.kind = (char_code == NEWLINE_CODE) ? KIND_NEWLINE : KIND_PUT;
         OP_CLEAR: q_cmd.kind = KIND_CLEAR;
         OP_READ:  q_cmd.kind = in_range ? KIND_READ : KIND_NOP;
         OP_NONE:  q_cmd.kind = KIND_NOP;
         default:  q_cmd.kind = KIND_NOP;
      endcase
   end

endmodule

// ===== src/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the front and the engine.
// ----------------------------------------------------------------------------
module tcw_queue
   import tcw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Console engine: screen store, cursor, scroll and fill sequencer, response
// register.
// ----------------------------------------------------------------------------
module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] text_color,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output rsp_type    rsp_data,
   output logic       init_busy
);

   localparam int CELLS        = ROWS * COLUMNS;
   localparam int ADDR_W       = $clog2(CELLS);
   localparam int ROW_W        = $clog2(ROWS);
   localparam int COL_W        = $clog2(COLUMNS);
   localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(SCROLL_CELLS);
   localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);

   logic [15:0] mem [CELLS];

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [7:0]        fill_color_ff, fill_color_in;
   logic              emit_ff, emit_in;
   logic              scrolled_ff, scrolled_in;
   logic              wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           out_ff, out_in;
   logic [15:0]       rd_data_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [15:0]       mem_wdata;
   logic              slot_free;
   logic              out_load;
   logic [15:0]       load_rd;
   logic              load_scr;
   logic [ADDR_W-1:0] cur_addr, cell_addr;
   logic [ROW_W+4:0]  row_ext;
   logic [COL_W+6:0]  col_ext;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign cur_addr  = ADDR_W'(row_ff) * ROW_SPAN + ADDR_W'(col_ff);
   assign cell_addr = ADDR_W'(q_cmd.row) * ROW_SPAN + ADDR_W'(q_cmd.col);
   assign init_busy = (state_ff == ST_FILL) && !emit_ff;

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      fill_color_in = fill_color_ff;
      emit_in       = emit_ff;
      scrolled_in   = scrolled_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      q_pop         = 1'b0;
      out_load      = 1'b0;
      load_rd       = '0;
      load_scr      = 1'b0;
      // pending scroll copy write by default
      mem_we        = wr_pend_ff;
      mem_waddr     = wr_addr_ff;
      mem_wdata     = rd_data_ff;
      mem_raddr     = scan_ff + ROW_SPAN;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  KIND_PUT, KIND_NEWLINE: begin
                     if (q_cmd.kind == KIND_PUT) begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_addr;
                        mem_wdata = {text_color, q_cmd.ch};
                     end
                     if (q_cmd.kind == KIND_PUT && col_ff != COL_LAST) begin
                        col_in   = col_ff + 1'b1;
                        out_load = 1'b1;
                     end else begin
                        col_in = '0;
                        if (row_ff != ROW_LAST) begin
                           row_in   = row_ff + 1'b1;
                           out_load = 1'b1;
                        end else begin
                           scan_in       = '0;
                           fill_color_in = text_color;
                           scrolled_in   = 1'b1;
                           emit_in       = 1'b1;
                           state_in      = ST_SCROLL;
                        end
                     end
                  end
                  KIND_CLEAR: begin
                     row_in        = '0;
                     col_in        = '0;
                     scan_in       = '0;
                     fill_color_in = text_color;
                     scrolled_in   = 1'b0;
                     emit_in       = 1'b1;
                     state_in      = ST_FILL;
                  end
                  KIND_READ: begin
                     mem_raddr = cell_addr;
                     state_in  = ST_READ;
                  end
                  KIND_NOP: begin
                     out_load = 1'b1;
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            out_load = 1'b1;
            load_rd  = rd_data_ff;
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            // read a cell one row below, write it back in the next cycle
            if (scan_ff != COPY_END) begin
               wr_pend_in = 1'b1;
               wr_addr_in = scan_ff;
               scan_in    = scan_ff + 1'b1;
            end else begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            mem_wdata = {fill_color_ff, SPACE_CODE};
            if (scan_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
               out_load = emit_ff;
               load_scr = scrolled_ff;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   end

   // cursor outputs keep only the bits that the response fields hold
   assign row_ext = {5'b0, row_in};
   assign col_ext = {7'b0, col_in};

   always_comb begin
      out_in = out_ff;
      if (out_load) begin
         out_in.cursor_row = row_ext[4:0];
         out_in.cursor_col = col_ext[6:0];
         out_in.read_char  = load_rd[7:0];
         out_in.read_color = load_rd[15:8];
         out_in.scrolled   = load_scr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         scan_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         fill_color_ff <= COLOR_RESET;
         emit_ff       <= 1'b0;
         scrolled_ff   <= 1'b0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         fill_color_ff <= fill_color_in;
         emit_ff       <= emit_in;
         scrolled_ff   <= scrolled_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      out_ff     <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = out_ff;

endmodule

// ===== src/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_writer_core_defines.svh"

module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   localparam logic [4:0] ROW_BOTTOM = 5'(ROWS - 1);

   // a stalled response keeps its payload
   `TCW_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // a scroll leaves the cursor at the start of the bottom row
   `TCW_ASSERT_RST(a_scroll_cursor, clock, reset, rsp_tvalid && rsp_tdata[28] |-> rsp_tdata[11:5] == 7'd0 && rsp_tdata[4:0] == ROW_BOTTOM, "cursor not at bottom row start after scroll")

   // a scrolling put never carries read data
   `TCW_ASSERT_RST(a_scroll_no_read, clock, reset, rsp_tvalid && rsp_tdata[28] |-> rsp_tdata[27:12] == 16'd0, "read data on a scrolling response")

   // the store clear after reset holds off requests
   `TCW_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !req_tready && !rsp_tvalid, "request accepted during reset clear")

endmodule

bind text_console_writer_core tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/text_console_writer_core_test.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core_test
// Self-checking stream testbench for the text console writer core.
// ----------------------------------------------------------------------------
// A clocked driver feeds requests from a pending queue. The queue is filled by
// a stimulus process. That process starts with a short directed set: reads of
// the reset screen, reads out of range, high character bytes, the unused op
// and a clear. Random bursts follow: text runs, newline runs that scroll,
// reads, clears and noise. The bursts run in phases, and the attribute byte
// is rewritten while the core is idle between phases. A screen and cursor
// model predicts each response. A monitor compares every response field by
// field with the oldest prediction. Both sides idle at random, and at one
// point the receiver holds off long enough to back the core up.
// ----------------------------------------------------------------------------
module text_console_writer_core_test;
   import tcw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = ROWS * COLUMNS;
   localparam int PHASES     = 6;
   localparam int PHASE_REQS = 222;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_LEN   = 600;
   localparam int HOLD_AT    = 300;

   typedef struct {
      logic [1:0] op;
      logic [7:0] ch;
      logic [4:0] row;
      logic [6:0] col;
   } req_item;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // char_code, cell_row, cell_col, zero pad
   logic [1:0]  req_tuser = '0;    // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // cursor_row, cursor_col, read_char,
                                   // read_color, scrolled, zero pad
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   // screen model
   logic [15:0] screen [0:CELLS-1];
   int          cur_row;
   int          cur_col;
   logic [7:0]  ink;

   req_item pending_reqs [$];
   rsp_type expected_rsp [$];
   req_item next_req;

   int  req_queued = 0;
   int  req_taken  = 0;
   int  rsp_seen   = 0;
   int  errors     = 0;
   int  n_scroll   = 0;
   int  n_clear    = 0;
   int  n_read     = 0;
   int  n_colors   = 0;
   int  idle_count = 0;
   bit  req_fire   = 1'b0;
   bit  no_idle    = 1'b0;
   int  gap_left   = 0;
   int  stall_left = 0;
   int  hold_left  = 0;
   bit  hold_done  = 1'b0;

   text_console_writer_core #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++)
         screen[i] = {ink, SPACE_CODE};
   endfunction

   function automatic logic advance_row();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
         for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
            screen[i] = {ink, SPACE_CODE};
         cur_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type console_step(req_item it);
      rsp_type r;
      r = '0;
      case (it.op)
         OP_PUT: begin
            if (it.ch == NEWLINE_CODE) begin
               r.scrolled = advance_row();
            end else begin
               screen[cur_row * COLUMNS + cur_col] = {ink, it.ch};
               cur_col++;
               if (cur_col >= COLUMNS)
                  r.scrolled = advance_row();
            end
         end
         OP_CLEAR: begin
            blank_screen();
            cur_row = 0;
            cur_col = 0;
            n_clear++;
         end
         OP_READ: begin
            n_read++;
            if (it.row < ROWS && it.col < COLUMNS)
               {r.read_color, r.read_char} = screen[it.row * COLUMNS + it.col];
         end
         default: ;
      endcase
      if (r.scrolled)
         n_scroll++;
      r.cursor_row = cur_row[4:0];
      r.cursor_col = cur_col[6:0];
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         errors++;
      end
   endtask

   // model, scoreboard and watchdog
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         ink = COLOR_RESET;
         cur_row = 0;
         cur_col = 0;
         blank_screen();
         req_fire = 1'b0;
      end else begin
         if (csr_wr_en)
            ink = csr_wr_data;
         req_fire = req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[28:0]);
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("cursor_row", int'(want.cursor_row), int'(got.cursor_row));
               check_field("cursor_col", int'(want.cursor_col), int'(got.cursor_col));
               check_field("read_char", int'(want.read_char), int'(got.read_char));
               check_field("read_color", int'(want.read_color), int'(got.read_color));
               check_field("scrolled", int'(want.scrolled), int'(got.scrolled));
            end
         end
         if (req_fire) begin
            expected_rsp.push_back(console_step(
               '{req_tuser, req_tdata[7:0], req_tdata[12:8], req_tdata[19:13]}));
            req_taken++;
         end
         if (req_fire || (rsp_tvalid && rsp_tready))
            idle_count = 0;
         else
            idle_count++;
         if (idle_count >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // hold the offered item until it is taken
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         next_req = pending_reqs.pop_front();
         req_tuser  <= next_req.op;
         req_tdata  <= {4'b0, next_req.col, next_req.row, next_req.ch};
         req_tvalid <= 1'b1;
         gap_left = no_idle ? 0 : pick_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response receiver, with one long hold-off to back the core up
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && req_taken >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   task automatic push_req(logic [1:0] op, logic [7:0] ch, logic [4:0] row,
                           logic [6:0] col);
      pending_reqs.push_back('{op, ch, row, col});
      req_queued++;
   endtask

   task automatic wait_idle();
      while (req_taken != req_queued || expected_rsp.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_color(logic [7:0] value);
      wait_idle();
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      n_colors++;
   endtask

   // one burst of related requests; returns how many it queued
   task automatic add_burst(output int count);
      int kind;
      int len;
      logic [4:0] row;
      logic [6:0] col;
      kind = $urandom_range(0, 99);
      count = 0;
      if (kind < 35) begin
         // text run, now and then long enough to wrap
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                            : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
               push_req(OP_PUT, NEWLINE_CODE, 5'($urandom), 7'($urandom));
            else
               push_req(OP_PUT, 8'($urandom_range(0, 255)), 5'($urandom),
                        7'($urandom));
         end
         count = len;
      end else if (kind < 50) begin
         len = $urandom_range(1, 20);
         for (int i = 0; i < len; i++)
            push_req(OP_PUT, NEWLINE_CODE, 5'($urandom), 7'($urandom));
         count = len;
      end else if (kind < 80) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 4))
               0, 1: begin
                  // text tends to land near the bottom after scrolls
                  row = 5'($urandom_range(ROWS - 3, ROWS - 1));
                  col = 7'($urandom_range(0, 15));
               end
               2, 3: begin
                  row = 5'($urandom_range(0, ROWS - 1));
                  col = 7'($urandom_range(0, COLUMNS - 1));
               end
               default: begin
                  row = 5'($urandom_range(0, 31));
                  col = 7'($urandom_range(0, 127));
               end
            endcase
            push_req(OP_READ, 8'($urandom), row, col);
         end
         count = len;
      end else if (kind < 85) begin
         push_req(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
         count = 1;
      end else if (kind < 92) begin
         len = $urandom_range(1, 3);
         for (int i = 0; i < len; i++)
            push_req(OP_NONE, 8'($urandom), 5'($urandom), 7'($urandom));
         count = len;
      end else begin
         push_req(2'($urandom_range(0, 3)), 8'($urandom), 5'($urandom),
                  7'($urandom));
         count = 1;
      end
   endtask

   initial begin
      int n;
      int phase_count;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset screen, out-of-range reads, high bytes, unused op, clear
      push_req(OP_READ, 8'h00, 5'd0, 7'd0);
      push_req(OP_READ, 8'hFF, 5'd24, 7'd79);
      push_req(OP_READ, 8'h00, 5'd25, 7'd0);
      push_req(OP_READ, 8'h00, 5'd0, 7'd80);
      push_req(OP_READ, 8'h00, 5'd31, 7'd127);
      push_req(OP_PUT, 8'h41, 5'd0, 7'd0);
      push_req(OP_PUT, 8'hFF, 5'd31, 7'd127);
      push_req(OP_PUT, 8'h80, 5'd0, 7'd0);
      push_req(OP_PUT, 8'h00, 5'd0, 7'd0);
      push_req(OP_PUT, NEWLINE_CODE, 5'd0, 7'd0);
      push_req(OP_NONE, 8'hFF, 5'd31, 7'd127);
      push_req(OP_NONE, 8'h00, 5'd0, 7'd0);
      push_req(OP_READ, 8'h00, 5'd0, 7'd0);
      push_req(OP_READ, 8'h00, 5'd0, 7'd1);
      push_req(OP_READ, 8'h00, 5'd0, 7'd2);
      push_req(OP_PUT, 8'h7E, 5'd0, 7'd0);
      push_req(OP_CLEAR, 8'hFF, 5'd31, 7'd127);
      push_req(OP_READ, 8'h00, 5'd0, 7'd0);
      push_req(OP_READ, 8'h00, 5'd1, 7'd0);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 0)
            set_color(8'hFF);
         else if (p == 1)
            set_color(8'h00);
         else
            set_color(8'($urandom_range(0, 255)));
         no_idle = (p == 3);
         phase_count = 0;
         while (phase_count < PHASE_REQS) begin
            add_burst(n);
            phase_count += n;
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      @(negedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp.size());
         errors++;
      end
      $display("covered %0d requests and %0d responses over %0d attribute settings",
               req_taken, rsp_seen, n_colors);
      $display("including %0d scrolls, %0d clears and %0d cell reads",
               n_scroll, n_clear, n_read);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_writer_core.sv
src/tcw_checker.sv
tb/text_console_writer_core_test.sv
